// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by running_sensitivity_indices.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants of the running sensitivity index estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  // sizing
  localparam int MAX_PARAMS  = 8;
  localparam int MAX_SAMPLES = 65536;

  // field and state widths
  localparam int DATA_W  = 16;
  localparam int PIDX_W  = 3;
  localparam int NP_W    = 4;
  localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SB_W    = 33;
  localparam int SQ_W    = 47;
  localparam int PS_W    = 49;
  localparam int IDX_W   = 24;

  // shared unit widths
  localparam int MA_W    = 18;
  localparam int MB_W    = 33;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ALU_W   = 66;
  localparam int DEN_W   = 64;

  // operand split points
  localparam int CHUNK_W  = 32;
  localparam int SB_SPLIT = 16;

  // divider: 16 fraction bits, 25 quotient bits cover every unsaturated index
  localparam int FRAC_W    = 16;
  localparam int Q_W       = IDX_W + 1;
  localparam int PRE_SHIFT = Q_W - FRAC_W;
  localparam int DIV_STEPS = Q_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int IDX_MAX     = 2 ** (IDX_W - 1) - 1;
  localparam int IDX_MIN_MAG = 2 ** (IDX_W - 1);

  // input beat
  typedef struct packed {
    logic signed [DATA_W-1:0] out_a;
    logic signed [DATA_W-1:0] out_b;
    logic signed [DATA_W-1:0] out_c;
    logic        [PIDX_W-1:0] param_index;
  } rsi_in_t;

  // result beat
  typedef struct packed {
    logic        [COUNT_W-1:0] sample_count;
    logic        [PIDX_W-1:0]  param_id;
    logic signed [IDX_W-1:0]   first_order;
    logic signed [IDX_W-1:0]   total_order;
    logic                      no_variance;
    logic                      saturated;
  } rsi_out_t;

  // shared unit request
  typedef struct packed {
    logic                    mul_en;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic        [ALU_W-1:0] add_x;
    logic        [ALU_W-1:0] add_y;
    logic                    add_sub;
  } alu_req_t;

  // shared unit response
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic        [ALU_W-1:0]  sum;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/rsi_alu.sv =====
// ----------------------------------------------------------------------------
// rsi_alu
// Shared arithmetic unit: registered signed multiplier and a wide add/subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_alu
  import rsi_pkg::*;
(
  input  wire logic     clk,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic signed [PROD_W-1:0] prod;

  // signed product, registered
  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      prod <= PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
    end
  end

  // two's complement add or subtract
  always_comb begin
    rsp.prod = prod;
    rsp.sum  = req.add_x + (req.add_sub ? ~req.add_y : req.add_y) + ALU_W'(req.add_sub);
  end

endmodule

`default_nettype wire

// ===== sv/running_sensitivity_indices.sv =====
// ----------------------------------------------------------------------------
// running_sensitivity_indices
// Running first-order and total-effect sensitivity indices over a sample stream.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  item     | in        | item_valid/stall   | rsi_in_t  (A, B, C outputs, param)
//  result   | out       | result_valid/stall | rsi_out_t (count, param, indices, flags)
//  cfg      | in        | cfg_valid/ready    | num_params, 4 bits
//
//  An item runs 11 products through the shared multiplier and adder, each a
//  multiply state then an add state, then two divisions that retire one
//  quotient bit a cycle on the 66-bit adder.
//  When the variance is not positive the numerator products and divisions are skipped.
//  item_stall is high while an item is in work; a finished result waits in the
//  output register and the next item is accepted meanwhile.
//  rst is synchronous and clears the counts, sums and num_params (to 1).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module running_sensitivity_indices
  import rsi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire rsi_in_t         item,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output rsi_out_t             result,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [NP_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_DLOAD, ST_DCHK, ST_DSTEP, ST_DFIN, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    J_SQ, J_FST, J_TOT, J_V0, J_V1, J_V2, J_V3, J_F0, J_F1, J_T0, J_T1
  } job_t;

  state_t state;
  job_t   job;
  job_t   job_next;

  // configuration and running state
  logic [NP_W-1:0]           num_params;
  logic [COUNT_W-1:0]        count;
  logic signed [SB_W-1:0]    sum_base;
  logic [SQ_W-1:0]           sum_base_sq;
  logic signed [PS_W-1:0]    sum_first [MAX_PARAMS];
  logic signed [PS_W-1:0]    sum_total [MAX_PARAMS];
  logic                      full;

  // item in work
  logic signed [DATA_W-1:0]  a_r;
  logic signed [DATA_W-1:0]  b_r;
  logic signed [DATA_W-1:0]  c_r;
  logic [PIDX_W-1:0]         p_r;
  logic                      do_sq;
  logic                      acc_en;

  // products, numerators and divider
  logic [ALU_W-1:0]          acc;
  logic [DEN_W-1:0]          den;
  logic [ALU_W-1:0]          num_f;
  logic [ALU_W-1:0]          num_t;
  logic [DEN_W-1:0]          rem;
  logic [Q_W-1:0]            dq;
  logic [DCNT_W-1:0]         dcnt;
  logic                      div_sel;
  logic                      dneg;
  logic signed [IDX_W-1:0]   fo_r;
  logic signed [IDX_W-1:0]   to_r;
  logic                      nov_r;
  logic                      sat_r;

  alu_req_t                  alu_req;
  alu_rsp_t                  alu_rsp;

  // combinational helpers
  logic [NP_W-1:0]           k_eff;
  logic                      upd0;
  logic                      hit_full;
  logic [COUNT_W-1:0]        count_n;
  logic                      acc_en_n;
  logic signed [PS_W-1:0]    sf_sel;
  logic signed [PS_W-1:0]    st_sel;
  logic [ALU_W-1:0]          prod_x;
  logic [ALU_W-1:0]          num_sel;
  logic [ALU_W-1:0]          num_neg;
  logic [DEN_W-1:0]          div_trial;
  logic                      div_ge;
  logic [Q_W-1:0]            q_lim;
  logic                      q_over;
  logic [Q_W-1:0]            q_mag;
  logic [Q_W-1:0]            q_res;

  rsi_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;

  // effective items per sample and the accept-time update decision
  always_comb begin
    if (num_params == '0) begin
      k_eff = NP_W'(1);
    end else if (int'(num_params) > MAX_PARAMS) begin
      k_eff = NP_W'(MAX_PARAMS);
    end else begin
      k_eff = num_params;
    end
    upd0     = (item.param_index == '0) && !full;
    hit_full = upd0 && (count >= COUNT_W'(MAX_SAMPLES));
    count_n  = (upd0 && !hit_full) ? count + COUNT_W'(1) : count;
    acc_en_n = !(full || hit_full) && (count_n != '0)
               && (int'(item.param_index) < int'(k_eff));
  end

  // per-parameter sums of the item in work
  always_comb begin
    if (int'(p_r) < MAX_PARAMS) begin
      sf_sel = sum_first[p_r];
      st_sel = sum_total[p_r];
    end else begin
      sf_sel = '0;
      st_sel = '0;
    end
  end

  assign prod_x = ALU_W'(alu_rsp.prod);

  // divider helpers
  always_comb begin
    num_sel   = div_sel ? num_t : num_f;
    num_neg   = -num_sel;
    div_trial = {rem[DEN_W-2:0], dq[Q_W-1]};
    div_ge    = !alu_rsp.sum[ALU_W-1];
    q_lim     = dneg ? Q_W'(IDX_MIN_MAG) : Q_W'(IDX_MAX);
    q_over    = (dq > q_lim);
    q_mag     = q_over ? q_lim : dq;
    q_res     = dneg ? -q_mag : q_mag;
  end

  // job order
  always_comb begin
    unique case (job)
      J_SQ:    job_next = J_FST;
      J_FST:   job_next = J_TOT;
      J_TOT:   job_next = J_V0;
      J_V0:    job_next = J_V1;
      J_V1:    job_next = J_V2;
      J_V2:    job_next = J_V3;
      J_V3:    job_next = J_F0;
      J_F0:    job_next = J_F1;
      J_F1:    job_next = J_T0;
      J_T0:    job_next = J_T1;
      J_T1:    job_next = J_SQ;
      default: job_next = J_SQ;
    endcase
  end

  // shared unit operand select
  always_comb begin
    alu_req        = '0;
    alu_req.mul_en = (state == ST_MUL);

    // multiplier operands
    unique case (job)
      J_SQ: begin
        alu_req.mul_a = MA_W'(a_r);
        alu_req.mul_b = MB_W'(a_r);
      end
      J_FST: begin
        alu_req.mul_a = MA_W'(c_r) - MA_W'(a_r);
        alu_req.mul_b = MB_W'(b_r);
      end
      J_TOT: begin
        alu_req.mul_a = MA_W'(a_r) - MA_W'(c_r);
        alu_req.mul_b = MB_W'(a_r);
      end
      J_V0: begin
        alu_req.mul_a = MA_W'(count);
        alu_req.mul_b = MB_W'(sum_base_sq[CHUNK_W-1:0]);
      end
      J_V1: begin
        alu_req.mul_a = MA_W'(count);
        alu_req.mul_b = MB_W'(sum_base_sq[SQ_W-1:CHUNK_W]);
      end
      J_V2: begin
        alu_req.mul_a = MA_W'(sum_base[SB_SPLIT-1:0]);
        alu_req.mul_b = sum_base;
      end
      J_V3: begin
        alu_req.mul_a = MA_W'($signed(sum_base[SB_W-1:SB_SPLIT]));
        alu_req.mul_b = sum_base;
      end
      J_F0: begin
        alu_req.mul_a = MA_W'(count);
        alu_req.mul_b = MB_W'(sf_sel[CHUNK_W-1:0]);
      end
      J_F1: begin
        alu_req.mul_a = MA_W'(count);
        alu_req.mul_b = MB_W'($signed(sf_sel[PS_W-1:CHUNK_W]));
      end
      J_T0: begin
        alu_req.mul_a = MA_W'(count);
        alu_req.mul_b = MB_W'(st_sel[CHUNK_W-1:0]);
      end
      J_T1: begin
        alu_req.mul_a = MA_W'(count);
        alu_req.mul_b = MB_W'($signed(st_sel[PS_W-1:CHUNK_W]));
      end
      default: begin
        alu_req.mul_a = '0;
        alu_req.mul_b = '0;
      end
    endcase

    // adder operands
    if (state == ST_ADD) begin
      unique case (job) inside
        J_SQ: begin
          alu_req.add_x = ALU_W'(sum_base_sq);
          alu_req.add_y = prod_x;
        end
        J_FST: begin
          alu_req.add_x = ALU_W'(sf_sel);
          alu_req.add_y = prod_x;
        end
        J_TOT: begin
          alu_req.add_x = ALU_W'(st_sel);
          alu_req.add_y = prod_x;
        end
        J_V0, J_F0, J_T0: begin
          alu_req.add_x = '0;
          alu_req.add_y = prod_x;
        end
        J_V1, J_F1, J_T1: begin
          alu_req.add_x = acc;
          alu_req.add_y = prod_x << CHUNK_W;
        end
        J_V2: begin
          alu_req.add_x   = acc;
          alu_req.add_y   = prod_x;
          alu_req.add_sub = 1'b1;
        end
        J_V3: begin
          alu_req.add_x   = acc;
          alu_req.add_y   = prod_x << SB_SPLIT;
          alu_req.add_sub = 1'b1;
        end
        default: begin
          alu_req.add_x = '0;
          alu_req.add_y = '0;
        end
      endcase
    end else if (state == ST_DCHK) begin
      alu_req.add_x   = ALU_W'(rem >> PRE_SHIFT);
      alu_req.add_y   = ALU_W'(den);
      alu_req.add_sub = 1'b1;
    end else if (state == ST_DSTEP) begin
      alu_req.add_x   = ALU_W'(div_trial);
      alu_req.add_y   = ALU_W'(den);
      alu_req.add_sub = 1'b1;
    end
  end

  // sequencer, running state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      job          <= J_SQ;
      num_params   <= NP_W'(1);
      count        <= '0;
      sum_base     <= '0;
      sum_base_sq  <= '0;
      full         <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        sum_first[i] <= '0;
        sum_total[i] <= '0;
      end
    end else begin
      // configuration beat
      if (cfg_valid && cfg_ready) begin
        num_params <= cfg_data;
      end

      // result beat taken, unless a new one is loaded in the same cycle
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            a_r    <= item.out_a;
            b_r    <= item.out_b;
            c_r    <= item.out_c;
            p_r    <= item.param_index;
            do_sq  <= upd0 && !hit_full;
            acc_en <= acc_en_n;
            nov_r  <= 1'b0;
            sat_r  <= 1'b0;
            count  <= count_n;
            if (hit_full) begin
              full <= 1'b1;
            end
            if (upd0 && !hit_full) begin
              sum_base <= sum_base + SB_W'(item.out_a);
            end
            job   <= J_SQ;
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          state <= ST_ADD;
        end

        ST_ADD: begin
          job <= job_next;
          unique case (job)
            J_SQ: begin
              if (do_sq) begin
                sum_base_sq <= alu_rsp.sum[SQ_W-1:0];
              end
              state <= ST_MUL;
            end
            J_FST: begin
              if (acc_en) begin
                sum_first[p_r] <= alu_rsp.sum[PS_W-1:0];
              end
              state <= ST_MUL;
            end
            J_TOT: begin
              if (acc_en) begin
                sum_total[p_r] <= alu_rsp.sum[PS_W-1:0];
              end
              state <= ST_MUL;
            end
            J_V3: begin
              den <= alu_rsp.sum[DEN_W-1:0];
              // variance zero or negative: indices forced to zero
              if (alu_rsp.sum[ALU_W-1] || (alu_rsp.sum == '0)) begin
                nov_r <= 1'b1;
                fo_r  <= '0;
                to_r  <= '0;
                state <= ST_DONE;
              end else begin
                state <= ST_MUL;
              end
            end
            J_F1: begin
              num_f <= alu_rsp.sum;
              state <= ST_MUL;
            end
            J_T1: begin
              num_t   <= alu_rsp.sum;
              div_sel <= 1'b0;
              state   <= ST_DLOAD;
            end
            default: begin
              acc   <= alu_rsp.sum;
              state <= ST_MUL;
            end
          endcase
        end

        // numerator magnitude
        ST_DLOAD: begin
          dneg  <= num_sel[ALU_W-1];
          rem   <= num_sel[ALU_W-1] ? num_neg[DEN_W-1:0] : num_sel[DEN_W-1:0];
          state <= ST_DCHK;
        end

        // integer part too large: quotient clips; else the division steps are set up
        ST_DCHK: begin
          if (!alu_rsp.sum[ALU_W-1]) begin
            dq    <= '1;
            state <= ST_DFIN;
          end else begin
            dq    <= {rem[PRE_SHIFT-1:0], FRAC_W'(0)};
            rem   <= rem >> PRE_SHIFT;
            dcnt  <= '0;
            state <= ST_DSTEP;
          end
        end

        // restoring division, one quotient bit a cycle
        ST_DSTEP: begin
          rem  <= div_ge ? alu_rsp.sum[DEN_W-1:0] : div_trial;
          dq   <= {dq[Q_W-2:0], div_ge};
          dcnt <= dcnt + DCNT_W'(1);
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= ST_DFIN;
          end
        end

        // clip and sign
        ST_DFIN: begin
          if (q_over) begin
            sat_r <= 1'b1;
          end
          if (!div_sel) begin
            fo_r    <= q_res[IDX_W-1:0];
            div_sel <= 1'b1;
            state   <= ST_DLOAD;
          end else begin
            to_r  <= q_res[IDX_W-1:0];
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            result.sample_count <= count;
            result.param_id     <= p_r;
            result.first_order  <= fo_r;
            result.total_order  <= to_r;
            result.no_variance  <= nov_r;
            result.saturated    <= sat_r;
            result_valid        <= 1'b1;
            state               <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= COUNT_W'(MAX_SAMPLES), "count beyond sample store")
  `ASSERT_NEXT(a_full_freezes, clk, rst, full, full && $stable(count) && $stable(sum_base), "sums moved after store full")
  `ASSERT_IMPL(a_rem_below_den, clk, rst, state == ST_DSTEP, rem < den, "divider remainder not below divisor")
  `ASSERT_IMPL(a_nov_zero, clk, rst, result_valid && result.no_variance, (result.first_order == '0) && (result.total_order == '0) && !result.saturated, "no-variance result carries indices")

endmodule

`default_nettype wire
